// File: src/lqci_pkg.sv
`default_nettype none
package lqci_pkg;

  localparam int WORLD_BITS     = 16;
  localparam int DEPTH_BITS     = 4;
  localparam int LEVEL_BITS     = 4;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int NUM_LANES      = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WORLD_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WORLD_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TREE_DEPTH   = 2'd2;

  localparam logic [WORLD_BITS-1:0] RST_WORLD_WIDTH  = 16'd640;
  localparam logic [WORLD_BITS-1:0] RST_WORLD_HEIGHT = 16'd480;
  localparam logic [DEPTH_BITS-1:0] RST_TREE_DEPTH   = 4'd3;

  // corner lanes: top-left and bottom-right, x and y
  localparam int LANE_LTX = 0;
  localparam int LANE_LTY = 1;
  localparam int LANE_RBX = 2;
  localparam int LANE_RBY = 3;

  // effective configuration seen by the pipeline
  typedef struct packed {
    logic [WORLD_BITS-1:0] width_eff;
    logic [WORLD_BITS-1:0] height_eff;
    logic [DEPTH_BITS-1:0] depth;
  } cfg_t;

  function automatic logic [WORLD_BITS-1:0] lane_world(cfg_t c, int lane);
    logic [WORLD_BITS-1:0] w;
    if (lane == LANE_LTY || lane == LANE_RBY) begin
      w = c.height_eff;
    end else begin
      w = c.width_eff;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// File: src/lqci_ifs.sv
`default_nettype none
interface lqci_box_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] obj_x;
  logic signed [COORD_BITS-1:0] obj_y;
  logic signed [COORD_BITS-1:0] box_off_x;
  logic signed [COORD_BITS-1:0] box_off_y;
  logic        [COORD_BITS-1:0] box_width;
  logic        [COORD_BITS-1:0] box_height;

  modport source (output valid, obj_x, obj_y, box_off_x, box_off_y, box_width, box_height,
                  input ready);
  modport sink (input valid, obj_x, obj_y, box_off_x, box_off_y, box_width, box_height,
                output ready);
endinterface

interface lqci_result_if #(
  parameter int INDEX_BITS = 17
);
  import lqci_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] cell_index;
  logic [LEVEL_BITS-1:0] cell_level;

  modport source (output valid, cell_index, cell_level, input ready);
  modport sink (input valid, cell_index, cell_level, output ready);
endinterface

interface lqci_cfg_if;
  import lqci_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/linear_quadtree_cell_index.sv
// An accepted box beat reaches its result beat through two corner stages, one
// divide cell per tree level and two encode stages.
// Throughput: one box per cycle while the sink is ready; the row of restoring-divide
// cells takes one quotient bit per cell, so depth only sets the row length, not the rate.
// The whole pipeline holds only while a result waits and the sink is not ready.
// Reset clears all valid bits and loads world 640 x 480, depth 3.
`default_nettype none
module linear_quadtree_cell_index #(
  parameter int MAX_DEPTH  = 8,
  parameter int COORD_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  lqci_box_if.sink     box,
  lqci_result_if.source result,
  lqci_cfg_if.sink     cfg
);
  import lqci_pkg::*;

  logic [WORLD_BITS-1:0] world_width;
  logic [WORLD_BITS-1:0] world_height;
  logic [DEPTH_BITS-1:0] tree_depth;
  cfg_t                  cfg_view;
  logic                  en;

  logic [MAX_DEPTH:0]                   stage_valid;
  logic [NUM_LANES-1:0][WORLD_BITS-1:0] stage_rem [MAX_DEPTH+1];
  logic [NUM_LANES-1:0][MAX_DEPTH-1:0]  stage_quo [MAX_DEPTH+1];

  logic                  enc_valid;
  logic [2*MAX_DEPTH:0]  enc_index;
  logic [LEVEL_BITS-1:0] enc_level;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_width  <= RST_WORLD_WIDTH;
      world_height <= RST_WORLD_HEIGHT;
      tree_depth   <= RST_TREE_DEPTH;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WORLD_WIDTH:  world_width  <= cfg.data[WORLD_BITS-1:0];
        REG_WORLD_HEIGHT: world_height <= cfg.data[WORLD_BITS-1:0];
        REG_TREE_DEPTH:   tree_depth   <= cfg.data[DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a zero world acts as one unit, depth saturates at the row length
  always_comb begin
    cfg_view.width_eff  = (world_width == '0) ? WORLD_BITS'(1) : world_width;
    cfg_view.height_eff = (world_height == '0) ? WORLD_BITS'(1) : world_height;
    cfg_view.depth      = (tree_depth > DEPTH_BITS'(MAX_DEPTH)) ?
                          DEPTH_BITS'(MAX_DEPTH) : tree_depth;
  end

  // advance every stage unless the output beat is stuck
  assign en        = !enc_valid || result.ready;
  assign box.ready = en;

  lqci_corner #(
    .COORD_BITS(COORD_BITS)
  ) u_corner (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg_view),
    .in_valid  (box.valid),
    .obj_x     (box.obj_x),
    .obj_y     (box.obj_y),
    .box_off_x (box.box_off_x),
    .box_off_y (box.box_off_y),
    .box_width (box.box_width),
    .box_height(box.box_height),
    .out_valid (stage_valid[0]),
    .out_rem   (stage_rem[0])
  );

  assign stage_quo[0] = '0;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    lqci_div_cell #(
      .MAX_DEPTH(MAX_DEPTH),
      .STEP     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cfg      (cfg_view),
      .in_valid (stage_valid[i]),
      .in_rem   (stage_rem[i]),
      .in_quo   (stage_quo[i]),
      .out_valid(stage_valid[i+1]),
      .out_rem  (stage_rem[i+1]),
      .out_quo  (stage_quo[i+1])
    );
  end

  lqci_encode #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_encode (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg_view),
    .in_valid (stage_valid[MAX_DEPTH]),
    .in_quo   (stage_quo[MAX_DEPTH]),
    .out_valid(enc_valid),
    .out_index(enc_index),
    .out_level(enc_level)
  );

  assign result.valid      = enc_valid;
  assign result.cell_index = enc_index;
  assign result.cell_level = enc_level;

`ifndef SYNTHESIS
  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.cell_level <= cfg_view.depth)
    else $error("result level above configured depth");

  a_rem_x_below_world: assert property (@(posedge clk) disable iff (rst)
    stage_valid[MAX_DEPTH] |-> stage_rem[MAX_DEPTH][LANE_LTX] < cfg_view.width_eff)
    else $error("divide remainder not below world width");

  a_rem_y_below_world: assert property (@(posedge clk) disable iff (rst)
    stage_valid[MAX_DEPTH] |-> stage_rem[MAX_DEPTH][LANE_RBY] < cfg_view.height_eff)
    else $error("divide remainder not below world height");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> $stable(stage_valid))
    else $error("pipeline moved while result stalled");
`endif

endmodule
`default_nettype wire

// File: src/lqci_corner.sv
`default_nettype none
module lqci_corner #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst,
  input  wire logic                                              en,
  input  wire lqci_pkg::cfg_t                                    cfg,
  input  wire logic                                              in_valid,
  input  wire logic signed [COORD_BITS-1:0]                      obj_x,
  input  wire logic signed [COORD_BITS-1:0]                      obj_y,
  input  wire logic signed [COORD_BITS-1:0]                      box_off_x,
  input  wire logic signed [COORD_BITS-1:0]                      box_off_y,
  input  wire logic        [COORD_BITS-1:0]                      box_width,
  input  wire logic        [COORD_BITS-1:0]                      box_height,
  output logic                                                   out_valid,
  output logic [lqci_pkg::NUM_LANES-1:0][lqci_pkg::WORLD_BITS-1:0] out_rem
);
  import lqci_pkg::*;

  localparam int CB       = COORD_BITS + 2;
  localparam int CMP_BITS = (CB > WORLD_BITS + 1) ? CB : WORLD_BITS + 1;

  logic signed [CB-1:0] corner_next [NUM_LANES];
  logic signed [CB-1:0] corner      [NUM_LANES];
  logic                 corner_valid;
  logic [NUM_LANES-1:0][WORLD_BITS-1:0] rem_next;

  always_comb begin
    corner_next[LANE_LTX] = CB'(obj_x) + CB'(box_off_x);
    corner_next[LANE_LTY] = CB'(obj_y) + CB'(box_off_y);
    // an empty box ends one unit before it starts
    corner_next[LANE_RBX] = corner_next[LANE_LTX] + $signed(CB'(box_width)) - CB'(1);
    corner_next[LANE_RBY] = corner_next[LANE_LTY] + $signed(CB'(box_height)) - CB'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_valid <= 1'b0;
    end else if (en) begin
      corner_valid <= in_valid;
    end
    if (en) begin
      corner <= corner_next;
    end
  end

  // clamp each corner into [0, world-1]
  always_comb begin
    logic signed [CMP_BITS-1:0] c_ext;
    logic signed [CMP_BITS-1:0] w_ext;
    logic        [WORLD_BITS-1:0] w;
    for (int l = 0; l < NUM_LANES; l++) begin
      w     = lane_world(cfg, l);
      c_ext = CMP_BITS'(corner[l]);
      w_ext = $signed(CMP_BITS'(w));
      if (c_ext < 0) begin
        rem_next[l] = '0;
      end else if (c_ext >= w_ext) begin
        rem_next[l] = w - WORLD_BITS'(1);
      end else begin
        rem_next[l] = c_ext[WORLD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= corner_valid;
    end
    if (en) begin
      out_rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

// File: src/lqci_div_cell.sv
`default_nettype none
module lqci_div_cell #(
  parameter int MAX_DEPTH = 8,
  parameter int STEP      = 0
) (
  input  wire logic                                                clk,
  input  wire logic                                                rst,
  input  wire logic                                                en,
  input  wire lqci_pkg::cfg_t                                      cfg,
  input  wire logic                                                in_valid,
  input  wire logic [lqci_pkg::NUM_LANES-1:0][lqci_pkg::WORLD_BITS-1:0] in_rem,
  input  wire logic [lqci_pkg::NUM_LANES-1:0][MAX_DEPTH-1:0]           in_quo,
  output logic                                                     out_valid,
  output logic [lqci_pkg::NUM_LANES-1:0][lqci_pkg::WORLD_BITS-1:0] out_rem,
  output logic [lqci_pkg::NUM_LANES-1:0][MAX_DEPTH-1:0]           out_quo
);
  import lqci_pkg::*;

  logic                                 active;
  logic [NUM_LANES-1:0][WORLD_BITS-1:0] rem_next;
  logic [NUM_LANES-1:0][MAX_DEPTH-1:0]  quo_next;

  // steps past the configured depth pass the beat through unchanged
  assign active = DEPTH_BITS'(STEP) < cfg.depth;

  always_comb begin
    logic [WORLD_BITS:0]   r2;
    logic [WORLD_BITS:0]   w_ext;
    logic [WORLD_BITS:0]   diff;
    logic                  ge;
    logic [MAX_DEPTH-1:0]  quo_sh;
    for (int l = 0; l < NUM_LANES; l++) begin
      r2     = {in_rem[l], 1'b0};
      w_ext  = {1'b0, lane_world(cfg, l)};
      diff   = r2 - w_ext;
      ge     = r2 >= w_ext;
      quo_sh = in_quo[l] << 1;
      if (active) begin
        rem_next[l] = ge ? diff[WORLD_BITS-1:0] : r2[WORLD_BITS-1:0];
        quo_next[l] = quo_sh | MAX_DEPTH'(ge);
      end else begin
        rem_next[l] = in_rem[l];
        quo_next[l] = in_quo[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_rem <= rem_next;
      out_quo <= quo_next;
    end
  end

endmodule
`default_nettype wire

// File: src/lqci_encode.sv
`default_nettype none
module lqci_encode #(
  parameter int MAX_DEPTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      en,
  input  wire lqci_pkg::cfg_t                            cfg,
  input  wire logic                                      in_valid,
  input  wire logic [lqci_pkg::NUM_LANES-1:0][MAX_DEPTH-1:0] in_quo,
  output logic                                           out_valid,
  output logic [2*MAX_DEPTH:0]                           out_index,
  output logic [lqci_pkg::LEVEL_BITS-1:0]                out_level
);
  import lqci_pkg::*;

  localparam int CODE_BITS  = 2 * MAX_DEPTH;
  localparam int INDEX_BITS = 2 * MAX_DEPTH + 1;

  logic [CODE_BITS-1:0]  code_lt;
  logic [CODE_BITS-1:0]  code_rb;
  logic [CODE_BITS-1:0]  code_diff;
  logic [DEPTH_BITS-1:0] span_next;

  logic                  mid_valid;
  logic [CODE_BITS-1:0]  lt_code;
  logic [LEVEL_BITS-1:0] level;
  logic [DEPTH_BITS-1:0] span;

  logic [CODE_BITS-1:0]  shifted;
  logic [CODE_BITS-1:0]  offset;

  // interleave cell coordinates, x in the even bits
  always_comb begin
    for (int k = 0; k < MAX_DEPTH; k++) begin
      code_lt[2*k]   = in_quo[LANE_LTX][k];
      code_lt[2*k+1] = in_quo[LANE_LTY][k];
      code_rb[2*k]   = in_quo[LANE_RBX][k];
      code_rb[2*k+1] = in_quo[LANE_RBY][k];
    end
    code_diff = code_lt ^ code_rb;
    span_next = '0;
    for (int k = 0; k < MAX_DEPTH; k++) begin
      if (code_diff[2*k +: 2] != 2'b00) begin
        span_next = DEPTH_BITS'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
    end
    if (en) begin
      lt_code <= code_lt;
      span    <= span_next;
      level   <= LEVEL_BITS'(cfg.depth - span_next);
    end
  end

  // level offset (4^level - 1)/3 is 0101..01 with one set bit per level
  always_comb begin
    shifted = lt_code >> {span, 1'b0};
    offset  = '0;
    for (int k = 0; k < MAX_DEPTH; k++) begin
      offset[2*k] = LEVEL_BITS'(k) < level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mid_valid;
    end
    if (en) begin
      out_index <= INDEX_BITS'(offset) + INDEX_BITS'(shifted);
      out_level <= level;
    end
  end

endmodule
`default_nettype wire
